// ===== hdl/stt_pkg.sv =====
// Shared types, codes and keyword tables of the source text tokenizer.
package stt_pkg;

    localparam int POS_W = 21;
    localparam logic [POS_W-1:0] MAX_TEXT_BYTES = 21'd1048576;
    localparam int NUM_RES = 3;
    localparam int TDATA_W = 56;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_CSTAR,
        MODE_STRING,
        MODE_NUMBER,
        MODE_WORD,
        MODE_EQ,
        MODE_BANG
    } mode_t;

    localparam logic [1:0] CLS_TOKEN = 2'd0;
    localparam logic [1:0] CLS_ERROR = 2'd1;
    localparam logic [1:0] CLS_WARN  = 2'd2;

    localparam logic [4:0] K_STRING  = 5'd0;
    localparam logic [4:0] K_INTEGER = 5'd1;
    localparam logic [4:0] K_KW0     = 5'd2;
    localparam logic [4:0] K_IDENT   = 5'd10;
    localparam logic [4:0] K_LPAREN  = 5'd11;
    localparam logic [4:0] K_RPAREN  = 5'd12;
    localparam logic [4:0] K_LBRACE  = 5'd13;
    localparam logic [4:0] K_RBRACE  = 5'd14;
    localparam logic [4:0] K_PLUS    = 5'd15;
    localparam logic [4:0] K_DOLLAR  = 5'd16;
    localparam logic [4:0] K_EQEQ    = 5'd17;
    localparam logic [4:0] K_EQ      = 5'd18;
    localparam logic [4:0] K_NEQ     = 5'd19;
    localparam logic [4:0] K_EOF     = 5'd20;

    localparam logic [2:0] D_OPEN_COMMENT = 3'd0;
    localparam logic [2:0] D_NL_STRING    = 3'd1;
    localparam logic [2:0] D_OPEN_STRING  = 3'd2;
    localparam logic [2:0] D_BAD_WORD     = 3'd3;
    localparam logic [2:0] D_LONE_BANG    = 3'd4;
    localparam logic [2:0] D_STRAY_SLASH  = 3'd5;
    localparam logic [2:0] D_BAD_CHAR     = 3'd6;
    localparam logic [2:0] D_NO_END       = 3'd7;

    // Members run from the top field down, so the packed word has
    // item_class in its lowest bits.
    typedef struct packed {
        logic [POS_W-1:0] lexeme_length;
        logic [POS_W-1:0] start_offset;
        logic [2:0]       diag_code;
        logic [4:0]       token_kind;
        logic [1:0]       item_class;
    } res_t;

    typedef struct packed {
        logic [1:0]  cnt;
        res_t [2:0]  res;
    } bundle_t;

    function automatic res_t mk_res(logic [1:0] cls, logic [4:0] kind, logic [2:0] code,
                                    logic [POS_W-1:0] start, logic [POS_W-1:0] len);
        res_t r;
        r.item_class    = cls;
        r.token_kind    = kind;
        r.diag_code     = code;
        r.start_offset  = start;
        r.lexeme_length = len;
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7A;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [3:0] kw_len(logic [2:0] i);
        logic [3:0] l;
        case (i)
            3'd0: l = 4'd5;
            3'd1: l = 4'd5;
            3'd2: l = 4'd2;
            3'd3: l = 4'd3;
            3'd4: l = 4'd6;
            3'd5: l = 4'd7;
            3'd6: l = 4'd4;
            default: l = 4'd5;
        endcase
        return l;
    endfunction

    // Keyword text, eight bytes per keyword, zero padded.
    function automatic logic [7:0] kw_char(logic [2:0] i, logic [2:0] k);
        logic [63:0] s;
        case (i)
            3'd0: s = {"print", 24'h0};
            3'd1: s = {"while", 24'h0};
            3'd2: s = {"if", 48'h0};
            3'd3: s = {"int", 40'h0};
            3'd4: s = {"string", 16'h0};
            3'd5: s = {"boolean", 8'h0};
            3'd6: s = {"true", 32'h0};
            default: s = {"false", 24'h0};
        endcase
        return s[8*(7-k) +: 8];
    endfunction

    // Drops every keyword that cannot hold byte c at place wlen.
    function automatic logic [7:0] kw_step(logic [7:0] cand, logic [3:0] wlen, logic [7:0] c);
        logic [7:0] n;
        n = cand;
        for (int i = 0; i < 8; i++) begin
            if (wlen >= kw_len(3'(i)) || kw_char(3'(i), wlen[2:0]) != c)
                n[i] = 1'b0;
        end
        return n;
    endfunction

endpackage

// ===== hdl/stt_front.sv =====
// Scanner front: takes bytes, keeps lexer state and forms each word's result bundle.
module stt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 action,
    input  logic [7:0]           source_byte,
    output stt_pkg::bundle_t     bundle,
    output logic                 push
);

    stt_pkg::mode_t mode_reg, mode_next;
    logic [stt_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [stt_pkg::POS_W-1:0] ls_reg, ls_next;
    logic [stt_pkg::POS_W-1:0] ens_reg, ens_next;
    logic [7:0] cand_reg, cand_next;
    logic [3:0] wlen_reg, wlen_next;
    logic       err_reg, err_next;
    logic       dol_reg, dol_next;

    stt_pkg::res_t [2:0] res;
    logic [1:0] cnt;
    logic       again;
    logic       kw_found;
    logic [4:0] kw_kind;
    logic [stt_pkg::POS_W-1:0] p, pnext, cur_len;
    logic [7:0] c;

    always_comb begin
        kw_found = 1'b0;
        kw_kind  = stt_pkg::K_IDENT;
        for (int i = 0; i < 8; i++) begin
            if (!kw_found && cand_reg[i] && stt_pkg::kw_len(3'(i)) == wlen_reg) begin
                kw_found = 1'b1;
                kw_kind  = stt_pkg::K_KW0 + 5'(i);
            end
        end
    end

    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        ls_next   = ls_reg;
        ens_next  = ens_reg;
        cand_next = cand_reg;
        wlen_next = wlen_reg;
        err_next  = err_reg;
        dol_next  = dol_reg;
        res       = '0;
        cnt       = 2'd0;
        again     = 1'b0;
        c         = source_byte;
        p         = pos_reg;
        pnext     = (pos_reg < stt_pkg::MAX_TEXT_BYTES) ? pos_reg + 1'b1 : pos_reg;
        cur_len   = pos_reg - ls_reg;

        if (action) begin
            case (mode_reg)
                stt_pkg::MODE_SLASH: begin
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                               stt_pkg::D_STRAY_SLASH, ls_reg, '0);
                    cnt = cnt + 1'b1;
                    err_next = 1'b1;
                end
                stt_pkg::MODE_COMMENT, stt_pkg::MODE_CSTAR: begin
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                               stt_pkg::D_OPEN_COMMENT, ls_reg, '0);
                    cnt = cnt + 1'b1;
                    err_next = 1'b1;
                end
                stt_pkg::MODE_STRING: begin
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                               stt_pkg::D_OPEN_STRING, ls_reg, '0);
                    cnt = cnt + 1'b1;
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_STRING,
                                               3'd0, ls_reg, cur_len);
                    cnt = cnt + 1'b1;
                    err_next = 1'b1;
                end
                stt_pkg::MODE_NUMBER: begin
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_INTEGER,
                                               3'd0, ls_reg, cur_len);
                    cnt = cnt + 1'b1;
                end
                stt_pkg::MODE_WORD: begin
                    if (!kw_found && wlen_reg != 4'd1) begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                                   stt_pkg::D_BAD_WORD, ls_reg, '0);
                        cnt = cnt + 1'b1;
                        err_next = 1'b1;
                    end
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, kw_kind, 3'd0,
                                               ls_reg, cur_len);
                    cnt = cnt + 1'b1;
                end
                stt_pkg::MODE_EQ: begin
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_EQ, 3'd0,
                                               ls_reg, 21'd1);
                    cnt = cnt + 1'b1;
                end
                stt_pkg::MODE_BANG: begin
                    res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                               stt_pkg::D_LONE_BANG, ls_reg, '0);
                    cnt = cnt + 1'b1;
                    err_next = 1'b1;
                end
                default: ;
            endcase
            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_EOF, 3'd0, p, '0);
            cnt = cnt + 1'b1;
            if (!err_next && ens_reg != '0 && !dol_reg && cnt != 2'd3) begin
                res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_WARN, 5'd0, stt_pkg::D_NO_END,
                                           ens_reg, '0);
                cnt = cnt + 1'b1;
            end
            mode_next = stt_pkg::MODE_IDLE;
            pos_next  = '0;
            ls_next   = '0;
            ens_next  = '0;
            cand_next = 8'hFF;
            wlen_next = 4'd0;
            err_next  = 1'b0;
            dol_next  = 1'b0;
        end else begin
            case (mode_reg)
                stt_pkg::MODE_SLASH: begin
                    if (c == "*") begin
                        mode_next = stt_pkg::MODE_COMMENT;
                    end else begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                                   stt_pkg::D_STRAY_SLASH, ls_reg, '0);
                        cnt = cnt + 1'b1;
                        err_next = 1'b1;
                        again = 1'b1;
                    end
                end
                stt_pkg::MODE_COMMENT: begin
                    if (c == "*")
                        mode_next = stt_pkg::MODE_CSTAR;
                end
                stt_pkg::MODE_CSTAR: begin
                    if (c == "/")
                        mode_next = stt_pkg::MODE_IDLE;
                    else if (c != "*")
                        mode_next = stt_pkg::MODE_COMMENT;
                end
                stt_pkg::MODE_STRING: begin
                    if (c == 8'h22) begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_STRING,
                                                   3'd0, ls_reg, cur_len + 1'b1);
                        cnt = cnt + 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                    end else if (c == 8'h0A || c == 8'h0D) begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                                   stt_pkg::D_NL_STRING, p, '0);
                        cnt = cnt + 1'b1;
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_STRING,
                                                   3'd0, ls_reg, cur_len);
                        cnt = cnt + 1'b1;
                        err_next = 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_NUMBER: begin
                    if (!stt_pkg::is_digit(c)) begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_INTEGER,
                                                   3'd0, ls_reg, cur_len);
                        cnt = cnt + 1'b1;
                        again = 1'b1;
                    end
                end
                stt_pkg::MODE_WORD: begin
                    if (stt_pkg::is_lower(c)) begin
                        cand_next = stt_pkg::kw_step(cand_reg, wlen_reg, c);
                        if (wlen_reg != 4'd15)
                            wlen_next = wlen_reg + 1'b1;
                    end else begin
                        if (!kw_found && wlen_reg != 4'd1) begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                                       stt_pkg::D_BAD_WORD, ls_reg, '0);
                            cnt = cnt + 1'b1;
                            err_next = 1'b1;
                        end
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, kw_kind, 3'd0,
                                                   ls_reg, cur_len);
                        cnt = cnt + 1'b1;
                        again = 1'b1;
                    end
                end
                stt_pkg::MODE_EQ: begin
                    if (c == "=") begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_EQEQ,
                                                   3'd0, ls_reg, 21'd2);
                        cnt = cnt + 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                    end else begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_EQ,
                                                   3'd0, ls_reg, 21'd1);
                        cnt = cnt + 1'b1;
                        again = 1'b1;
                    end
                end
                stt_pkg::MODE_BANG: begin
                    if (c == "=") begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_NEQ,
                                                   3'd0, ls_reg, 21'd2);
                        cnt = cnt + 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                    end else begin
                        res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                                   stt_pkg::D_LONE_BANG, ls_reg, '0);
                        cnt = cnt + 1'b1;
                        err_next = 1'b1;
                        again = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase

            // The byte that closed a construct, or any byte seen while idle.
            if (again) begin
                mode_next = stt_pkg::MODE_IDLE;
                if (!stt_pkg::is_ws(c)) begin
                    ls_next = p;
                    case (c) inside
                        "/": mode_next = stt_pkg::MODE_SLASH;
                        8'h22: mode_next = stt_pkg::MODE_STRING;
                        ["0":"9"]: mode_next = stt_pkg::MODE_NUMBER;
                        ["a":"z"]: begin
                            mode_next = stt_pkg::MODE_WORD;
                            cand_next = stt_pkg::kw_step(8'hFF, 4'd0, c);
                            wlen_next = 4'd1;
                        end
                        "=": mode_next = stt_pkg::MODE_EQ;
                        "!": mode_next = stt_pkg::MODE_BANG;
                        "(": begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_LPAREN,
                                                       3'd0, p, 21'd1);
                            cnt = cnt + 1'b1;
                        end
                        ")": begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_RPAREN,
                                                       3'd0, p, 21'd1);
                            cnt = cnt + 1'b1;
                        end
                        "{": begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_LBRACE,
                                                       3'd0, p, 21'd1);
                            cnt = cnt + 1'b1;
                        end
                        "}": begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_RBRACE,
                                                       3'd0, p, 21'd1);
                            cnt = cnt + 1'b1;
                        end
                        "+": begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_PLUS,
                                                       3'd0, p, 21'd1);
                            cnt = cnt + 1'b1;
                        end
                        "$": begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_TOKEN, stt_pkg::K_DOLLAR,
                                                       3'd0, p, 21'd1);
                            cnt = cnt + 1'b1;
                        end
                        default: begin
                            res[cnt] = stt_pkg::mk_res(stt_pkg::CLS_ERROR, 5'd0,
                                                       stt_pkg::D_BAD_CHAR, p, '0);
                            cnt = cnt + 1'b1;
                            err_next = 1'b1;
                        end
                    endcase
                end
            end

            if (!stt_pkg::is_ws(c)) begin
                ens_next = pnext;
                dol_next = (c == "$");
            end
            pos_next = pnext;
        end
    end

    assign bundle.cnt = cnt;
    assign bundle.res = res;
    assign push       = accept && cnt != 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= stt_pkg::MODE_IDLE;
            pos_reg  <= '0;
            ls_reg   <= '0;
            ens_reg  <= '0;
            cand_reg <= 8'hFF;
            wlen_reg <= 4'd0;
            err_reg  <= 1'b0;
            dol_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ls_reg   <= ls_next;
            ens_reg  <= ens_next;
            cand_reg <= cand_next;
            wlen_reg <= wlen_next;
            err_reg  <= err_next;
            dol_reg  <= dol_next;
        end
    end

endmodule

// ===== hdl/stt_queue.sv =====
// Two-entry queue of result bundles between scanner and output stage.
module stt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  stt_pkg::bundle_t  wr_bundle,
    input  logic              pop,
    output stt_pkg::bundle_t  rd_bundle,
    output logic              full,
    output logic              empty
);

    stt_pkg::bundle_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign empty     = count_reg == 2'd0;
    assign rd_bundle = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_bundle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/stt_back.sv =====
// Output stage: unpacks queued bundles into single results in an output register.
module stt_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  stt_pkg::bundle_t             head,
    input  logic                         empty,
    output logic                         pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [stt_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast
);

    logic          valid_reg, valid_next;
    stt_pkg::res_t data_reg, data_next;
    logic          last_reg, last_next;
    logic [1:0]    idx_reg, idx_next;
    logic          load, is_last;

    always_comb begin
        load       = (!valid_reg || m_axis_tready) && !empty;
        is_last    = idx_reg == head.cnt - 2'd1;
        pop        = load && is_last;
        valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);
        data_next  = load ? head.res[idx_reg] : data_reg;
        last_next  = load ? is_last : last_reg;
        idx_next   = load ? (is_last ? 2'd0 : idx_reg + 2'd1) : idx_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(stt_pkg::TDATA_W - $bits(stt_pkg::res_t)){1'b0}}, data_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
//
// The tokenizer takes one source byte per input word, or an end-of-text word
// (tuser high), and sends out one merged stream of tokens and diagnostics in
// source order. A byte word is accepted in every cycle while the two-entry
// bundle queue has room: the scanner does all per-byte mode and keyword work
// combinationally, so the input side sustains one word per clock. One
// input word can cause zero to three results; the output stage sends one
// result word per clock while tready is high, so a burst of multi-result
// bytes is limited by the output port at one result per cycle, and the queue
// absorbs short bursts. The first result of an accepted byte passes through
// the bundle queue and then the output register before it is shown. Offsets
// are byte offsets from the start of the text and stop at 2^20. After the
// end-of-text word all scanner state returns to its reset values and the
// next byte starts a new text. The last result caused by one input word
// carries tlast.
module source_text_tokenizer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // source_byte
    input  logic                        s_axis_tuser,  // action (1 = end of text)
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // item_class[1:0], token_kind[6:2], diag_code[9:7], start_offset[30:10],
    // lexeme_length[51:31], zero padding[55:52]
    output logic [stt_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast   // last_of_run
);

    stt_pkg::bundle_t new_bundle, head_bundle;
    logic accept, push, pop, full, empty;

    // A word is taken whenever the queue can hold whatever it produces.
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    stt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .action      (s_axis_tuser),
        .source_byte (s_axis_tdata),
        .bundle      (new_bundle),
        .push        (push)
    );

    stt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_bundle (new_bundle),
        .pop       (pop),
        .rd_bundle (head_bundle),
        .full      (full),
        .empty     (empty)
    );

    stt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head_bundle),
        .empty         (empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hdl/stt_checker.sv =====
// Port-level assertions for the tokenizer, bound to the top level.
module stt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [stt_pkg::TDATA_W-1:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word shown right after reset");

    a_diag_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != stt_pkg::CLS_TOKEN |->
            m_axis_tdata[51:31] == '0 && m_axis_tdata[6:2] == '0)
        else $error("diagnostic word carries token fields");

    a_token_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == stt_pkg::CLS_TOKEN |->
            m_axis_tdata[9:7] == '0 && m_axis_tdata[55:52] == '0)
        else $error("token word carries a diagnostic code or padding");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
